// ----- design/sbdc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbdc_pkg
// Shared types and constants for the single button dimmer control block.
// ----------------------------------------------------------------------------
package sbdc_pkg;

  // event codes reported with every result
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_TOGGLE = 2'd1;
  localparam logic [1:0] EV_STEP   = 2'd2;
  localparam logic [1:0] EV_DONE   = 2'd3;

  // register map, index = paddr / 4
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_PRESS_MIN  = 3'd0;
  localparam logic [2:0] REG_HOLD       = 3'd1;
  localparam logic [2:0] REG_HOLD_CAP   = 3'd2;
  localparam logic [2:0] REG_REPEAT     = 3'd3;
  localparam logic [2:0] REG_LEVEL_MIN  = 3'd4;
  localparam logic [2:0] REG_LEVEL_MAX  = 3'd5;

  // register reset values
  localparam logic [15:0] PRESS_MIN_RST = 16'd30;
  localparam logic [15:0] HOLD_RST      = 16'd500;
  localparam logic [15:0] HOLD_CAP_RST  = 16'd1000;
  localparam logic [7:0]  REPEAT_RST    = 8'd10;
  localparam logic [7:0]  LEVEL_MIN_RST = 8'd5;
  localparam logic [7:0]  LEVEL_MAX_RST = 8'd255;

  // state reset values
  localparam logic [7:0]  REPEAT_CNT_RST = 8'd255;
  localparam logic [7:0]  LEVEL_RST      = 8'd128;

  typedef struct packed {
    logic [15:0] press_min_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] hold_cap;
    logic [7:0]  repeat_ticks;
    logic [7:0]  level_min;
    logic [7:0]  level_max;
  } cfg_t;

  typedef struct packed {
    logic [15:0] held_count;
    logic [7:0]  repeat_count;
    logic        power_state;
    logic [7:0]  level;
    logic        step_down;
  } dim_state_t;

  typedef struct packed {
    logic       lamp_on;
    logic [7:0] duty_level;
    logic [1:0] event_code;
  } result_t;

endpackage

// ----- design/sbdc_core.sv -----
// ----------------------------------------------------------------------------
// sbdc_core
// Next-state and result logic for one tick: hold counting, event decision,
// lamp toggle, level stepping and direction reversal.
// ----------------------------------------------------------------------------
module sbdc_core import sbdc_pkg::*; (
  input  cfg_t       cfg,
  input  dim_state_t state,
  input  logic       button,
  output dim_state_t state_next,
  output result_t    result
);

  logic [15:0] held_inc;
  logic [1:0]  ev_raw;
  logic [1:0]  ev;
  logic [7:0]  level_step;

  // hold counter, saturating at the cap
  assign held_inc = (state.held_count < cfg.hold_cap) ? (state.held_count + 16'd1)
                                                      : state.held_count;

  // raw event and counter updates
  always_comb begin
    ev_raw                  = EV_NONE;
    state_next.held_count   = state.held_count;
    state_next.repeat_count = state.repeat_count;
    if (button) begin
      state_next.held_count = held_inc;
      if (held_inc >= cfg.hold_ticks) begin
        if (state.repeat_count < cfg.repeat_ticks) begin
          state_next.repeat_count = state.repeat_count + 8'd1;
        end else begin
          state_next.repeat_count = 8'd0;
          ev_raw                  = EV_STEP;
        end
      end
    end else begin
      if (state.held_count >= cfg.press_min_ticks &&
          state.held_count < cfg.hold_ticks) begin
        ev_raw = EV_TOGGLE;
      end else if (state.held_count >= cfg.hold_ticks &&
                   state.held_count <= cfg.hold_cap) begin
        ev_raw = EV_DONE;
      end
      state_next.held_count = 16'd0;
    end
  end

  // while off, any event switches the lamp on
  assign ev = (ev_raw != EV_NONE && !state.power_state) ? EV_TOGGLE : ev_raw;

  // one level up or down toward the limits
  always_comb begin
    level_step = state.level;
    if (!state.step_down) begin
      if (state.level < cfg.level_max) level_step = state.level + 8'd1;
    end else begin
      if (state.level > cfg.level_min) level_step = state.level - 8'd1;
    end
  end

  // apply the event
  always_comb begin
    state_next.power_state = state.power_state;
    state_next.level       = state.level;
    state_next.step_down   = state.step_down;
    case (ev)
      EV_TOGGLE: begin
        state_next.power_state = !state.power_state;
        if (!state.power_state) begin
          state_next.step_down = (state.level == cfg.level_max);
        end
      end
      EV_STEP: begin
        state_next.level = level_step;
      end
      EV_DONE: begin
        state_next.step_down = !state.step_down;
      end
      default: begin
      end
    endcase
  end

  // result fields
  assign result.lamp_on    = state_next.power_state;
  assign result.duty_level = state_next.power_state ? state_next.level : 8'd0;
  assign result.event_code = ev;

endmodule

// ----- design/single_button_dimmer_control.sv -----
// ----------------------------------------------------------------------------
// single_button_dimmer_control
// One button lamp dimmer, one tick item in and one result out per item.
//
//   port group   dir   handshake          payload
//   tick in      in    in_valid/in_ready  button_pressed
//   result out   out   out_valid/out_ready lamp_on, duty_level, event_code
//   config       in    apb psel/penable   paddr, pwdata, prdata
//
// one item per cycle sustained while out_ready stays high; a taken beat passes
// through the input register, then the result register, before its result leaves
// the tick logic is one pass of compares and 16-bit increments per cycle
// reset restores the register defaults and the lamp state, no clearing pass
// a stalled result register holds the input register, which then holds in_ready
// ----------------------------------------------------------------------------
module single_button_dimmer_control import sbdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // tick input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              button_pressed,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic              lamp_on,
  output logic [7:0]        duty_level,
  output logic [1:0]        event_code,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  dim_state_t state;
  dim_state_t state_next;
  result_t    result;
  logic       s1_valid;
  logic       s1_button;
  logic       s1_adv;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_min_ticks <= PRESS_MIN_RST;
      cfg.hold_ticks      <= HOLD_RST;
      cfg.hold_cap        <= HOLD_CAP_RST;
      cfg.repeat_ticks    <= REPEAT_RST;
      cfg.level_min       <= LEVEL_MIN_RST;
      cfg.level_max       <= LEVEL_MAX_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PRESS_MIN: cfg.press_min_ticks <= pwdata[15:0];
        REG_HOLD:      cfg.hold_ticks      <= pwdata[15:0];
        REG_HOLD_CAP:  cfg.hold_cap        <= pwdata[15:0];
        REG_REPEAT:    cfg.repeat_ticks    <= pwdata[7:0];
        REG_LEVEL_MIN: cfg.level_min       <= pwdata[7:0];
        REG_LEVEL_MAX: cfg.level_max       <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_PRESS_MIN: prdata = {16'd0, cfg.press_min_ticks};
      REG_HOLD:      prdata = {16'd0, cfg.hold_ticks};
      REG_HOLD_CAP:  prdata = {16'd0, cfg.hold_cap};
      REG_REPEAT:    prdata = {24'd0, cfg.repeat_ticks};
      REG_LEVEL_MIN: prdata = {24'd0, cfg.level_min};
      REG_LEVEL_MAX: prdata = {24'd0, cfg.level_max};
      default:       prdata = 32'd0;
    endcase
  end

  // input register, moves on when the result register is free or draining
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_button <= button_pressed;
    end
  end

  // tick logic
  sbdc_core u_core (
    .cfg        (cfg),
    .state      (state),
    .button     (s1_button),
    .state_next (state_next),
    .result     (result)
  );

  // lamp state, updated once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state.held_count   <= 16'd0;
      state.repeat_count <= REPEAT_CNT_RST;
      state.power_state  <= 1'b0;
      state.level        <= LEVEL_RST;
      state.step_down    <= 1'b0;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      lamp_on    <= result.lamp_on;
      duty_level <= result.duty_level;
      event_code <= result.event_code;
    end
  end

`ifndef SYNTHESIS
  // an off lamp always shows zero duty
  a_off_zero_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !lamp_on |-> duty_level == 8'd0)
    else $error("duty nonzero while lamp off");

  // a step is only taken while the lamp is on
  a_step_needs_power: assert property (@(posedge clk) disable iff (rst)
    s1_adv && result.event_code == EV_STEP |-> state.power_state)
    else $error("step event with lamp off");

  // step done reverses the direction
  a_done_flips_dir: assert property (@(posedge clk) disable iff (rst)
    s1_adv && result.event_code == EV_DONE |=> state.step_down != $past(state.step_down))
    else $error("step done did not reverse direction");

  // a processed beat always lands in the result register
  a_adv_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("result lost after processing");

  // a held beat waits in the input register
  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && s1_button == $past(s1_button))
    else $error("input register dropped a beat");
`endif

endmodule

// ----- bench/sbdc_checker.sv -----
// ----------------------------------------------------------------------------
// sbdc_checker
// Watches the tick, result and configuration ports of the dimmer, keeps its
// own copy of the dimmer state and registers, predicts the result of every
// accepted tick and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module sbdc_checker import sbdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              button_pressed,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              lamp_on,
  input  logic [7:0]        duty_level,
  input  logic [1:0]        event_code,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                lamp_out_pending,
  output int                mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t       dim_cfg;
  dim_state_t dim_st;
  result_t    lamp_out_q[$];
  int         errors = 0;

  assign mismatch_count = errors;

  // one tick of the dimmer: held counter, repeat counter, event, lamp update
  task automatic dim_next_result(input logic pressed, output result_t res);
    logic [1:0] ev;
    ev = EV_NONE;
    if (pressed) begin
      if (dim_st.held_count < dim_cfg.hold_cap)
        dim_st.held_count = dim_st.held_count + 16'd1;
      if (dim_st.held_count >= dim_cfg.hold_ticks) begin
        if (dim_st.repeat_count < dim_cfg.repeat_ticks) begin
          dim_st.repeat_count = dim_st.repeat_count + 8'd1;
        end else begin
          dim_st.repeat_count = 8'd0;
          ev = EV_STEP;
        end
      end
    end else begin
      if (dim_st.held_count >= dim_cfg.press_min_ticks &&
          dim_st.held_count < dim_cfg.hold_ticks)
        ev = EV_TOGGLE;
      else if (dim_st.held_count >= dim_cfg.hold_ticks &&
               dim_st.held_count <= dim_cfg.hold_cap)
        ev = EV_DONE;
      dim_st.held_count = 16'd0;
    end

    // with the lamp off any event switches it on
    if (ev != EV_NONE && !dim_st.power_state)
      ev = EV_TOGGLE;

    case (ev)
      EV_TOGGLE: begin
        dim_st.power_state = !dim_st.power_state;
        if (dim_st.power_state)
          dim_st.step_down = (dim_st.level == dim_cfg.level_max);
      end
      EV_STEP: begin
        if (!dim_st.step_down) begin
          if (dim_st.level < dim_cfg.level_max)
            dim_st.level = dim_st.level + 8'd1;
        end else if (dim_st.level > dim_cfg.level_min) begin
          dim_st.level = dim_st.level - 8'd1;
        end
      end
      EV_DONE: begin
        dim_st.step_down = !dim_st.step_down;
      end
      default: ;
    endcase

    res.lamp_on    = dim_st.power_state;
    res.duty_level = dim_st.power_state ? dim_st.level : 8'd0;
    res.event_code = ev;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      dim_cfg.press_min_ticks = PRESS_MIN_RST;
      dim_cfg.hold_ticks      = HOLD_RST;
      dim_cfg.hold_cap        = HOLD_CAP_RST;
      dim_cfg.repeat_ticks    = REPEAT_RST;
      dim_cfg.level_min       = LEVEL_MIN_RST;
      dim_cfg.level_max       = LEVEL_MAX_RST;
      dim_st.held_count       = 16'd0;
      dim_st.repeat_count     = REPEAT_CNT_RST;
      dim_st.power_state      = 1'b0;
      dim_st.level            = LEVEL_RST;
      dim_st.step_down        = 1'b0;
      lamp_out_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_PRESS_MIN: dim_cfg.press_min_ticks = pwdata[15:0];
          REG_HOLD:      dim_cfg.hold_ticks      = pwdata[15:0];
          REG_HOLD_CAP:  dim_cfg.hold_cap        = pwdata[15:0];
          REG_REPEAT:    dim_cfg.repeat_ticks    = pwdata[7:0];
          REG_LEVEL_MIN: dim_cfg.level_min       = pwdata[7:0];
          REG_LEVEL_MAX: dim_cfg.level_max       = pwdata[7:0];
          default: ;
        endcase
      end

      // tick beat
      if (in_valid && in_ready) begin
        dim_next_result(button_pressed, want);
        lamp_out_q.push_back(want);
      end

      // result beat
      if (out_valid && out_ready) begin
        got = {lamp_on, duty_level, event_code};
        if (lamp_out_q.size() == 0) begin
          $display("%0t: unexpected result lamp_on %0d duty_level %0d event_code %0d",
                   $time, got.lamp_on, got.duty_level, got.event_code);
          errors++;
        end else begin
          want = lamp_out_q.pop_front();
          if (got.lamp_on !== want.lamp_on) begin
            $display("%0t: lamp_on expected %0d actual %0d",
                     $time, want.lamp_on, got.lamp_on);
            errors++;
          end
          if (got.duty_level !== want.duty_level) begin
            $display("%0t: duty_level expected %0d actual %0d",
                     $time, want.duty_level, got.duty_level);
            errors++;
          end
          if (got.event_code !== want.event_code) begin
            $display("%0t: event_code expected %0d actual %0d",
                     $time, want.event_code, got.event_code);
            errors++;
          end
        end
      end
    end
    lamp_out_pending <= lamp_out_q.size();
  end

endmodule

// ----- bench/tb_single_button_dimmer_control.sv -----
// ----------------------------------------------------------------------------
// tb_single_button_dimmer_control
// Drives button ticks and register settings into the dimmer with random gaps
// and result stalls; a short directed press/hold/release sequence comes first,
// then phases of random press sequences under ordinary, extreme and disordered
// register settings. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_single_button_dimmer_control import sbdc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              button_pressed = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              lamp_on;
  logic [7:0]        duty_level;
  logic [1:0]        event_code;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int lamp_out_pending;
  int mismatch_count;
  bit no_idle = 1'b0;

  // directed press/hold/release pattern, first bit first
  localparam logic [0:26] DIRECTED_TICKS = 27'b010_110_1111111111_0_110_111111_0;

  single_button_dimmer_control i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .button_pressed (button_pressed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .lamp_on        (lamp_on),
    .duty_level     (duty_level),
    .event_code     (event_code),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  sbdc_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .button_pressed   (button_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .lamp_on          (lamp_on),
    .duty_level       (duty_level),
    .event_code       (event_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .lamp_out_pending (lamp_out_pending),
    .mismatch_count   (mismatch_count)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one register write: setup cycle, then access until pready
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_dimmer_regs(input cfg_t c);
    write_reg(REG_PRESS_MIN, 32'(c.press_min_ticks));
    write_reg(REG_HOLD,      32'(c.hold_ticks));
    write_reg(REG_HOLD_CAP,  32'(c.hold_cap));
    write_reg(REG_REPEAT,    32'(c.repeat_ticks));
    write_reg(REG_LEVEL_MIN, 32'(c.level_min));
    write_reg(REG_LEVEL_MAX, 32'(c.level_max));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (lamp_out_pending == 0);
    repeat (4) @(posedge clk);
  endtask

  // one tick beat, after a random gap
  task automatic send_tick(input logic pressed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(16, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    button_pressed <= pressed;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly press-hold-release sequences, some random button noise
  task automatic run_phase(input cfg_t c, input int budget,
                           input int min_hold, input int max_hold);
    int sent;
    int len;
    int rel;
    drain_results();
    load_dimmer_regs(c);
    sent = 0;
    while (sent < budget) begin
      no_idle = ($urandom_range(3, 0) == 0);
      if ($urandom_range(9, 0) < 8) begin
        len = $urandom_range(max_hold, min_hold);
        // keep the phase near its beat budget
        if (len > budget - sent)
          len = budget - sent;
        rel = $urandom_range(4, 1);
        repeat (len) send_tick(1'b1);
        repeat (rel) send_tick(1'b0);
        sent += len + rel;
      end else begin
        len = $urandom_range(12, 1);
        repeat (len) send_tick(1'($urandom_range(1, 0)));
        sent += len;
      end
      // occasionally let the pipeline run empty
      if ($urandom_range(15, 0) == 0)
        drain_results();
    end
  endtask

  // result side: random stall before each beat
  initial begin : result_sink
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(16, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus and verdict
  initial begin : tick_source
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short press, toggle, hold with steps up to the cap and the
    // top level, step done, toggle off, hold while off switches on at max
    load_dimmer_regs('{16'd2, 16'd5, 16'd8, 8'd1, 8'd126, 8'd130});
    for (int i = 0; i < 27; i++)
      send_tick(DIRECTED_TICKS[i]);

    // ordinary small thresholds
    run_phase('{16'd2, 16'd8, 16'd20, 8'd2, 8'd100, 8'd110}, 90, 0, 24);
    // all zero thresholds, disordered levels: every tick raises an event
    run_phase('{16'd0, 16'd0, 16'd0, 8'd0, 8'd255, 8'd0}, 60, 0, 6);
    // maximum thresholds: holds never reach stepping
    run_phase('{16'hffff, 16'hffff, 16'hffff, 8'd255, 8'd0, 8'd255}, 30, 0, 20);
    // long holds across much of the level range, step on every held tick
    run_phase('{16'd3, 16'd1, 16'hffff, 8'd0, 8'd0, 8'd255}, 150, 100, 300);
    // level range inverted, level starts outside it
    run_phase('{16'd1, 16'd4, 16'd6, 8'd3, 8'd200, 8'd50}, 60, 0, 10);
    // cap below hold threshold
    run_phase('{16'd1, 16'd6, 16'd4, 8'd2, 8'd10, 8'd20}, 60, 0, 8);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
